/* sv/playfair_digraph_encryptor_macros.svh */
// assertion macros for the playfair digraph encryptor
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_MACROS_SVH

// condition holds at every clock edge out of reset
`define PFDE_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define PFDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pfde_pkg.sv */
// types, constants and helper functions for the playfair digraph encryptor
package pfde_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam int Alpha = 26;
  localparam int Cells = 25;

  localparam letter_t LetterI = 5'd8;
  localparam letter_t LetterJ = 5'd9;
  localparam letter_t LetterZ = 5'd25;
  localparam cell_t   CellCount = 5'd25;
  localparam coord_t  LastCoord = 3'd4;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_KEY     = 2'd1,
    CMD_FINAL   = 2'd2,
    CMD_ENCRYPT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_CELL,
    S_SQUARE,
    S_DONE
  } state_e;

  typedef struct packed {
    cell_t addr_first;
    cell_t addr_second;
  } sq_addr_t;

  // saturate to z, then fold j onto i
  function automatic letter_t pair_letter(letter_t raw);
    letter_t v;
    v = (raw > LetterZ) ? LetterZ : raw;
    if (v == LetterJ) begin
      v = LetterI;
    end
    return v;
  endfunction

  function automatic coord_t cell_row(cell_t c);
    coord_t r;
    if (c >= 5'd20) begin
      r = 3'd4;
    end else if (c >= 5'd15) begin
      r = 3'd3;
    end else if (c >= 5'd10) begin
      r = 3'd2;
    end else if (c >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic coord_t cell_col(cell_t c);
    cell_t rest;
    rest = c - cell_t'({cell_row(c), 2'b00}) - cell_t'(cell_row(c));
    return rest[2:0];
  endfunction

  function automatic cell_t cell_at(coord_t row, coord_t col);
    return cell_t'({row, 2'b00}) + cell_t'(row) + cell_t'(col);
  endfunction

  function automatic coord_t coord_inc(coord_t c);
    return (c == LastCoord) ? 3'd0 : c + 3'd1;
  endfunction

endpackage

/* sv/pfde_if.sv */
// request and response channel interfaces
interface pfde_req_if;
  import pfde_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  letter_t    letter_first;
  letter_t    letter_second;

  modport source (output valid, cmd, letter_first, letter_second, input ready);
  modport sink (input valid, cmd, letter_first, letter_second, output ready);
endinterface

interface pfde_rsp_if;
  import pfde_pkg::*;
  logic       valid;
  logic       ready;
  letter_t    cipher_first;
  letter_t    cipher_second;
  logic [1:0] status;

  modport source (output valid, cipher_first, cipher_second, status, input ready);
  modport sink (input valid, cipher_first, cipher_second, status, output ready);
endinterface

/* sv/playfair_digraph_encryptor.sv */
// Playfair 5x5 key square builder and digraph encryptor, top level.
// One command is handled at a time; a finished response waits in an output
// register so the next command can be taken while it is unread. Clear and
// key-letter commands, and encrypt before finalize, go straight to the done
// state; encrypt does one letter-to-cell memory read, then one key-square
// read, and finalize walks over all 26 letters through the single write
// port of the two memories. Letters are coded 0 (a) to 25 (z).
`include "playfair_digraph_encryptor_macros.svh"

module playfair_digraph_encryptor (
  input logic         clk,
  input logic         rst,
  pfde_req_if.sink    req,
  pfde_rsp_if.source  rsp
);
  import pfde_pkg::*;

  state_e           state;
  state_e           state_next;
  logic [Alpha-1:0] letter_used;
  cell_t            fill_count;
  logic             square_ready;
  letter_t          walk;

  letter_t          key_square [Cells];
  cell_t            letter_cell [Alpha];

  cell_t            cell_q1;
  cell_t            cell_q2;
  letter_t          sq_q1;
  letter_t          sq_q2;
  sq_addr_t         sq_addr;

  letter_t          res_first;
  letter_t          res_second;
  status_e          res_status;

  logic             out_valid;
  letter_t          out_first;
  letter_t          out_second;
  status_e          out_status;

  logic             accept;
  logic             push;
  logic             clear;
  logic             used_hit;
  logic             key_ok;
  logic             fill_ok;
  logic             place;
  letter_t          place_letter;
  cmd_e             cmd;

  assign cmd       = cmd_e'(req.cmd);
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign push      = (state == S_DONE) && (!out_valid || rsp.ready);
  assign clear     = accept && (cmd == CMD_CLEAR);

  assign used_hit = (req.letter_first <= LetterZ) ? letter_used[req.letter_first] : 1'b0;
  assign key_ok   = (req.letter_first <= LetterZ) && (req.letter_first != LetterJ) &&
                    !used_hit && (fill_count < CellCount);
  assign fill_ok  = (walk != LetterJ) && !letter_used[walk] && (fill_count < CellCount);

  assign place        = (accept && (cmd == CMD_KEY) && key_ok) || ((state == S_FILL) && fill_ok);
  assign place_letter = (state == S_FILL) ? walk : req.letter_first;

  assign rsp.valid         = out_valid;
  assign rsp.cipher_first  = out_first;
  assign rsp.cipher_second = out_second;
  assign rsp.status        = out_status;

  pfde_pair_rule u_pair_rule (
    .cell_first  (cell_q1),
    .cell_second (cell_q2),
    .addr        (sq_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_FINAL:   state_next = S_FILL;
            CMD_ENCRYPT: state_next = square_ready ? S_CELL : S_DONE;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        if (walk == LetterZ) begin
          state_next = S_DONE;
        end
      end
      S_CELL:   state_next = S_SQUARE;
      S_SQUARE: state_next = S_DONE;
      S_DONE: begin
        if (push) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used  <= '0;
      fill_count   <= '0;
      square_ready <= 1'b0;
      walk         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (clear) begin
        letter_used  <= '0;
        fill_count   <= '0;
        square_ready <= 1'b0;
      end else if (place) begin
        letter_used[place_letter] <= 1'b1;
        fill_count                <= fill_count + 5'd1;
      end
      if ((state == S_FILL) && (walk == LetterZ)) begin
        square_ready <= 1'b1;
      end
      if (accept) begin
        walk <= '0;
      end else if (state == S_FILL) begin
        walk <= walk + 5'd1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // key square and letter-to-cell memories
  always_ff @(posedge clk) begin
    if (place) begin
      key_square[fill_count]    <= place_letter;
      letter_cell[place_letter] <= fill_count;
    end
    if (accept && (cmd == CMD_ENCRYPT)) begin
      cell_q1 <= letter_cell[pair_letter(req.letter_first)];
      cell_q2 <= letter_cell[pair_letter(req.letter_second)];
    end
    if (state == S_CELL) begin
      sq_q1 <= key_square[sq_addr.addr_first];
      sq_q2 <= key_square[sq_addr.addr_second];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_first  <= '0;
      res_second <= '0;
      res_status <= ST_OK;
      case (cmd)
        CMD_KEY: begin
          if (!key_ok) begin
            res_status <= ST_IGNORED;
          end
        end
        CMD_ENCRYPT: begin
          if (!square_ready) begin
            res_status <= ST_NOT_READY;
          end
        end
        default: ;
      endcase
    end else if (state == S_SQUARE) begin
      res_first  <= sq_q1;
      res_second <= sq_q2;
    end
    if (push) begin
      out_first  <= res_first;
      out_second <= res_second;
      out_status <= res_status;
    end
  end

  `PFDE_ASSERT_NOW(a_fill_bound, fill_count <= CellCount, "fill count beyond square size")
  `PFDE_ASSERT_NOW(a_ready_full, !square_ready || (fill_count == CellCount),
                   "square ready but not full")
  `PFDE_ASSERT_NOW(a_no_j_placed, !place || (place_letter != LetterJ), "letter j placed in square")
  `PFDE_ASSERT_NEXT(a_fill_done, (state == S_FILL) && (walk == LetterZ), square_ready,
                    "finalize walk ended without square ready")
  `PFDE_ASSERT_NOW(a_not_ready_zero, (state != S_DONE) || (res_status != ST_NOT_READY) ||
                   ((res_first == '0) && (res_second == '0)), "not-ready result with letters")

endmodule

/* sv/pfde_pair_rule.sv */
// playfair pair rule: maps two cell positions to the two cipher cell positions
module pfde_pair_rule (
  input  pfde_pkg::cell_t    cell_first,
  input  pfde_pkg::cell_t    cell_second,
  output pfde_pkg::sq_addr_t addr
);
  import pfde_pkg::*;

  coord_t row_first;
  coord_t col_first;
  coord_t row_second;
  coord_t col_second;

  always_comb begin
    row_first  = cell_row(cell_first);
    col_first  = cell_col(cell_first);
    row_second = cell_row(cell_second);
    col_second = cell_col(cell_second);
    if (row_first == row_second) begin
      addr.addr_first  = cell_at(row_first, coord_inc(col_first));
      addr.addr_second = cell_at(row_second, coord_inc(col_second));
    end else if (col_first == col_second) begin
      addr.addr_first  = cell_at(coord_inc(row_first), col_first);
      addr.addr_second = cell_at(coord_inc(row_second), col_second);
    end else begin
      addr.addr_first  = cell_at(row_first, col_second);
      addr.addr_second = cell_at(row_second, col_first);
    end
  end

endmodule
